FILE: hdl/orpd_pkg.sv
// ----------------------------------------------------------------------------
// orpd_pkg
// Shared types and constants for the position packet ring decoder.
// ----------------------------------------------------------------------------
package orpd_pkg;

  localparam int QUEUE_SLOTS = 8;
  localparam int IDX_W       = $clog2(QUEUE_SLOTS);

  // Operation codes of the kind field
  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_PEEK   = 2'd2;

  localparam logic [23:0] ADDR_MASK = 24'hFF_FFFF;

  // Altitude range offsets
  localparam logic [15:0] ALT_OFS_1 = 16'h1000;
  localparam logic [15:0] ALT_OFS_2 = 16'h3000;
  localparam logic [15:0] ALT_OFS_3 = 16'h7000;

  // Exact divide by 3 for dividends below 2**30: (x * DIV3_RECIP) >> DIV3_SHIFT
  localparam int          DIV3_SHIFT = 32;
  localparam logic [30:0] DIV3_RECIP = 31'(((64'd1 << DIV3_SHIFT) / 3) + 1);

  // Heading rounding: floor((h * HDG_SCALE + HDG_BIAS) / HDG_DIV)
  localparam logic [23:0] HDG_SCALE = 24'd10000;
  localparam logic [23:0] HDG_BIAS  = 24'd142222;
  localparam longint      HDG_DIV   = 284444;
  // Exact for dividends below 2**24
  localparam int          HDG_SHIFT = 43;
  localparam logic [24:0] HDG_RECIP = 25'(((64'd1 << HDG_SHIFT) / HDG_DIV) + 1);

  typedef struct packed {
    logic [23:0] station;
    logic [23:0] lat;
    logic [23:0] lon;
    logic [13:0] alt;
    logic [9:0]  head;
    logic [3:0]  atype;
  } orpd_entry_t;

  typedef struct packed {
    logic accept;    // input transaction taken this cycle
    logic read;      // fetch the head entry
    logic scale;     // form the scaled dividends
    logic load_out;  // divide and load the output register
  } orpd_cmd_t;

endpackage

FILE: hdl/orpd_in_if.sv
// ----------------------------------------------------------------------------
// orpd_in_if
// Input channel: one queue operation with its packet words.
// ----------------------------------------------------------------------------
interface orpd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] address_word;
  logic [31:0] latitude_word;
  logic [31:0] longitude_word;
  logic [31:0] altitude_word;
  logic [31:0] heading_word;

  modport source (
    output valid, kind, address_word, latitude_word, longitude_word,
           altitude_word, heading_word,
    input  ready
  );

  modport sink (
    input  valid, kind, address_word, latitude_word, longitude_word,
           altitude_word, heading_word,
    output ready
  );
endinterface

FILE: hdl/orpd_out_if.sv
// ----------------------------------------------------------------------------
// orpd_out_if
// Output channel: queue status and the decoded head packet.
// ----------------------------------------------------------------------------
interface orpd_out_if;
  logic               valid;
  logic               ready;
  logic               available;
  logic [23:0]        station_id;
  logic [3:0]         aircraft_type;
  logic [15:0]        altitude;
  logic [27:0]        latitude_micro;
  logic signed [28:0] longitude_micro;
  logic [5:0]         heading_code;

  modport source (
    output valid, available, station_id, aircraft_type, altitude,
           latitude_micro, longitude_micro, heading_code,
    input  ready
  );

  modport sink (
    input  valid, available, station_id, aircraft_type, altitude,
           latitude_micro, longitude_micro, heading_code,
    output ready
  );
endinterface

FILE: hdl/overwrite_ring_packet_decoder_top.sv
// ----------------------------------------------------------------------------
// overwrite_ring_packet_decoder_top
// Ring queue of position packets with a decoder for the head packet.
// ----------------------------------------------------------------------------
// Each input transaction adds a packet, removes the head or only peeks, and
// yields one result transaction with the non-empty flag and the decoded head
// packet (all decoded fields zero on an empty queue). The ring holds up to
// seven packets; an add into a full ring drops the oldest. An item passes from
// acceptance to a loaded output register through the pointer update and the
// store write, the registered store read, the scaling of the dividends and the
// reciprocal multipliers that divide by 3 and by the heading step. A new item
// is accepted only after the previous result has been loaded; a waiting result
// stalls only the final divide step.
module overwrite_ring_packet_decoder_top (
  input logic        clk,
  input logic        rst,
  orpd_in_if.sink    in_ch,
  orpd_out_if.source out_ch
);
  import orpd_pkg::*;

  orpd_cmd_t cmd;

  orpd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  orpd_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .kind            (in_ch.kind),
    .address_word    (in_ch.address_word),
    .latitude_word   (in_ch.latitude_word),
    .longitude_word  (in_ch.longitude_word),
    .altitude_word   (in_ch.altitude_word),
    .heading_word    (in_ch.heading_word),
    .available       (out_ch.available),
    .station_id      (out_ch.station_id),
    .aircraft_type   (out_ch.aircraft_type),
    .altitude        (out_ch.altitude),
    .latitude_micro  (out_ch.latitude_micro),
    .longitude_micro (out_ch.longitude_micro),
    .heading_code    (out_ch.heading_code)
  );

endmodule

FILE: hdl/orpd_ctrl.sv
// ----------------------------------------------------------------------------
// orpd_ctrl
// Sequencer: accept, fetch head, scale, divide and load the output register.
// ----------------------------------------------------------------------------
module orpd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output orpd_pkg::orpd_cmd_t cmd
);
  import orpd_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_READ   = 2'd1;
  localparam logic [1:0] ST_SCALE  = 2'd2;
  localparam logic [1:0] ST_DIVIDE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd.accept   = in_valid && in_ready;
    cmd.read     = (state == ST_READ);
    cmd.scale    = (state == ST_SCALE);
    cmd.load_out = (state == ST_DIVIDE) && out_free;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_READ;
      ST_READ:   state_next = ST_SCALE;
      ST_SCALE:  state_next = ST_DIVIDE;
      ST_DIVIDE: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("output register not marked full after load");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_READ))
    else $error("accepted transaction did not start the fetch");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIVIDE && out_valid && !out_ready) |=> (state == ST_DIVIDE) && out_valid)
    else $error("result overwritten while output stalled");
`endif

endmodule

FILE: hdl/orpd_datapath.sv
// ----------------------------------------------------------------------------
// orpd_datapath
// Ring pointers, packet store and the head packet decoder.
// ----------------------------------------------------------------------------
module orpd_datapath (
  input  logic                clk,
  input  logic                rst,
  input  orpd_pkg::orpd_cmd_t cmd,
  input  logic [1:0]          kind,
  input  logic [31:0]         address_word,
  input  logic [31:0]         latitude_word,
  input  logic [31:0]         longitude_word,
  input  logic [31:0]         altitude_word,
  input  logic [31:0]         heading_word,
  output logic                available,
  output logic [23:0]         station_id,
  output logic [3:0]          aircraft_type,
  output logic [15:0]         altitude,
  output logic [27:0]         latitude_micro,
  output logic signed [28:0]  longitude_micro,
  output logic [5:0]          heading_code
);
  import orpd_pkg::*;

  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] wr_idx;
  logic [IDX_W-1:0] rd_inc;
  logic [IDX_W-1:0] wr_inc;
  orpd_entry_t      mem [QUEUE_SLOTS];
  orpd_entry_t      new_entry;
  logic             do_write;

  // Fetch stage
  orpd_entry_t      head_q;
  logic             nonempty_q;

  // Scale stage
  logic [29:0]      lat_scaled;
  logic [29:0]      lon_scaled;
  logic             lon_neg;
  logic [23:0]      hdg_num;
  logic [23:0]      lon_mag;

  // Divide stage
  logic [60:0]      lat_prod;
  logic [60:0]      lon_prod;
  logic [48:0]      hdg_prod;
  logic [27:0]      lon_quot;
  logic [15:0]      alt_dec;
  logic [11:0]      alt_m;

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
    if (i == IDX_W'(QUEUE_SLOTS - 1)) begin
      return '0;
    end
    return i + 1'b1;
  endfunction

  assign rd_inc = next_slot(rd_idx);
  assign wr_inc = next_slot(wr_idx);

  always_comb begin
    new_entry.station = address_word[23:0] & ADDR_MASK;
    new_entry.lat     = latitude_word[23:0];
    new_entry.lon     = longitude_word[23:0];
    new_entry.alt     = altitude_word[13:0];
    new_entry.head    = heading_word[9:0];
    new_entry.atype   = heading_word[23:20];
  end

  assign do_write = cmd.accept && (kind == KIND_ADD);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx <= '0;
      wr_idx <= '0;
    end else if (cmd.accept) begin
      case (kind)
        KIND_ADD: begin
          // full ring: drop the oldest packet
          if (wr_inc == rd_idx) rd_idx <= rd_inc;
          wr_idx <= wr_inc;
        end
        KIND_REMOVE: begin
          if (rd_idx != wr_idx) rd_idx <= rd_inc;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_write) mem[wr_idx] <= new_entry;
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      head_q     <= mem[rd_idx];
      nonempty_q <= (rd_idx != wr_idx);
    end
  end

  // Magnitude of the two's complement longitude code
  assign lon_mag = head_q.lon[23] ? (24'h00_0000 - head_q.lon) : head_q.lon;

  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      lat_scaled <= {1'b0, head_q.lat, 5'b0} + {3'b0, head_q.lat, 3'b0};
      lon_scaled <= {lon_mag, 6'b0} + {2'b0, lon_mag, 4'b0};
      lon_neg    <= head_q.lon[23];
      hdg_num    <= 24'(head_q.head) * HDG_SCALE + HDG_BIAS;
    end
  end

  assign lat_prod = 61'(lat_scaled) * 61'(DIV3_RECIP);
  assign lon_prod = 61'(lon_scaled) * 61'(DIV3_RECIP);
  assign hdg_prod = 49'(hdg_num) * 49'(HDG_RECIP);
  assign lon_quot = lon_prod[DIV3_SHIFT +: 28];

  assign alt_m = head_q.alt[11:0];
  always_comb begin
    case (head_q.alt[13:12])
      2'd0:    alt_dec = {4'b0, alt_m};
      2'd1:    alt_dec = ALT_OFS_1 + {3'b0, alt_m, 1'b0};
      2'd2:    alt_dec = ALT_OFS_2 + {2'b0, alt_m, 2'b0};
      default: alt_dec = ALT_OFS_3 + {1'b0, alt_m, 3'b0};
    endcase
  end

  // Output register; decoded fields read zero on an empty queue
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      available       <= nonempty_q;
      station_id      <= nonempty_q ? head_q.station : '0;
      aircraft_type   <= nonempty_q ? head_q.atype : '0;
      altitude        <= nonempty_q ? alt_dec : '0;
      latitude_micro  <= nonempty_q ? lat_prod[DIV3_SHIFT +: 28] : '0;
      if (!nonempty_q) begin
        longitude_micro <= '0;
      end else if (lon_neg) begin
        longitude_micro <= -$signed({1'b0, lon_quot});
      end else begin
        longitude_micro <= $signed({1'b0, lon_quot});
      end
      heading_code    <= nonempty_q ? hdg_prod[HDG_SHIFT +: 6] : '0;
    end
  end

endmodule
